FILE: hdl/bmhq_pkg.sv
// Shared constants and types of the binary max-heap queue.
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic                     re;
        logic [ADDR_W-1:0]        raddr_a;
        logic [ADDR_W-1:0]        raddr_b;
    } t_mem_req;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic [CNT_W-1:0]         element_total;
    } t_result;

endpackage

FILE: hdl/bmhq_mem.sv
// Heap store: one write port, two read ports with registered read data.
module bmhq_mem (
    input  logic                              i_clk,
    input  bmhq_pkg::t_mem_req                i_req,
    output logic signed [bmhq_pkg::DATA_W-1:0] o_rdata_a,
    output logic signed [bmhq_pkg::DATA_W-1:0] o_rdata_b
);

    logic signed [bmhq_pkg::DATA_W-1:0] r_mem [bmhq_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata_a <= r_mem[i_req.raddr_a];
            o_rdata_b <= r_mem[i_req.raddr_b];
        end
    end

endmodule

FILE: hdl/bmhq_ctrl.sv
// Sift sequencer with the shared signed comparator of the heap queue.
module bmhq_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_req_type,
    input  logic signed [bmhq_pkg::DATA_W-1:0] i_item_value,
    output logic                               o_busy,
    output logic                               o_done,
    input  logic                               i_take,
    output bmhq_pkg::t_result                  o_result,
    output bmhq_pkg::t_mem_req                 o_mem_req,
    input  logic signed [bmhq_pkg::DATA_W-1:0] i_rdata_a,
    input  logic signed [bmhq_pkg::DATA_W-1:0] i_rdata_b
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_CHK  = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_DN_LOAD = 8'b0000_1000,
        S_DN_CHK  = 8'b0001_0000,
        S_DN_CH   = 8'b0010_0000,
        S_DN_CMP  = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state                              r_state,    n_state;
    logic [bmhq_pkg::CNT_W-1:0]          r_cnt,      n_cnt;
    logic [bmhq_pkg::CNT_W-1:0]          r_pos,      n_pos;
    logic [bmhq_pkg::CNT_W-1:0]          r_best_pos, n_best_pos;
    logic signed [bmhq_pkg::DATA_W-1:0]  r_val,      n_val;
    logic signed [bmhq_pkg::DATA_W-1:0]  r_best_val, n_best_val;
    logic signed [bmhq_pkg::DATA_W-1:0]  r_removed,  n_removed;
    logic [bmhq_pkg::STAT_W-1:0]         r_status,   n_status;
    logic signed [bmhq_pkg::DATA_W-1:0]  r_top;

    // shared comparator
    logic signed [bmhq_pkg::DATA_W-1:0] cmp_a, cmp_b;
    logic                               cmp_lt;

    logic [bmhq_pkg::CNT_W:0]   w_left, w_left_m1, w_cnt_x;
    logic [bmhq_pkg::CNT_W-1:0] w_pos_m1, w_parent, w_parent_m1, w_cnt_m1;
    logic                       w_right_ok;

    assign cmp_lt = cmp_a < cmp_b;

    assign w_left      = {r_pos, 1'b0};
    assign w_left_m1   = w_left - 1'b1;
    assign w_cnt_x     = {1'b0, r_cnt};
    assign w_pos_m1    = r_pos - 1'b1;
    assign w_parent    = {1'b0, r_pos[bmhq_pkg::CNT_W-1:1]};
    assign w_parent_m1 = w_parent - 1'b1;
    assign w_cnt_m1    = r_cnt - 1'b1;
    assign w_right_ok  = w_left < w_cnt_x;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_best_pos = r_best_pos;
        n_val      = r_val;
        n_best_val = r_best_val;
        n_removed  = r_removed;
        n_status   = r_status;
        o_mem_req  = '0;
        cmp_a      = i_rdata_a;
        cmp_b      = r_val;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_removed = '0;
                    n_status  = bmhq_pkg::ST_OK;
                    if (i_req_type == bmhq_pkg::REQ_INSERT) begin
                        if (r_cnt == bmhq_pkg::CAP_CNT) begin
                            n_status = bmhq_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt   = r_cnt + 1'b1;
                            n_pos   = r_cnt + 1'b1;
                            n_val   = i_item_value;
                            n_state = S_UP_CHK;
                        end
                    end else if (r_cnt == '0) begin
                        n_status = bmhq_pkg::ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        // fetch the last entry; it refills the root
                        n_removed         = r_top;
                        o_mem_req.re      = 1'b1;
                        o_mem_req.raddr_a = w_cnt_m1[bmhq_pkg::ADDR_W-1:0];
                        n_cnt             = w_cnt_m1;
                        n_pos             = bmhq_pkg::CNT_W'(1);
                        n_state           = S_DN_LOAD;
                    end
                end
            end
            S_UP_CHK: begin
                if (r_pos == bmhq_pkg::CNT_W'(1)) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = '0;
                    o_mem_req.wdata = r_val;
                    n_state         = S_DONE;
                end else begin
                    o_mem_req.re      = 1'b1;
                    o_mem_req.raddr_a = w_parent_m1[bmhq_pkg::ADDR_W-1:0];
                    n_state           = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // parent strictly smaller: it moves down into the hole
                cmp_a           = i_rdata_a;
                cmp_b           = r_val;
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = w_pos_m1[bmhq_pkg::ADDR_W-1:0];
                if (cmp_lt) begin
                    o_mem_req.wdata = i_rdata_a;
                    n_pos           = w_parent;
                    n_state         = S_UP_CHK;
                end else begin
                    o_mem_req.wdata = r_val;
                    n_state         = S_DONE;
                end
            end
            S_DN_LOAD: begin
                n_val   = i_rdata_a;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (w_left > w_cnt_x) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = w_pos_m1[bmhq_pkg::ADDR_W-1:0];
                    o_mem_req.wdata = r_val;
                    n_state         = S_DONE;
                end else begin
                    o_mem_req.re      = 1'b1;
                    o_mem_req.raddr_a = w_left_m1[bmhq_pkg::ADDR_W-1:0];
                    o_mem_req.raddr_b = w_left[bmhq_pkg::ADDR_W-1:0];
                    n_state           = S_DN_CH;
                end
            end
            S_DN_CH: begin
                // left child wins ties
                cmp_a = i_rdata_a;
                cmp_b = i_rdata_b;
                if (w_right_ok && cmp_lt) begin
                    n_best_val = i_rdata_b;
                    n_best_pos = w_left[bmhq_pkg::CNT_W-1:0] + 1'b1;
                end else begin
                    n_best_val = i_rdata_a;
                    n_best_pos = w_left[bmhq_pkg::CNT_W-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmp_a           = r_val;
                cmp_b           = r_best_val;
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = w_pos_m1[bmhq_pkg::ADDR_W-1:0];
                if (cmp_lt) begin
                    o_mem_req.wdata = r_best_val;
                    n_pos           = r_best_pos;
                    n_state         = S_DN_CHK;
                end else begin
                    o_mem_req.wdata = r_val;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_best_pos <= n_best_pos;
        r_val      <= n_val;
        r_best_val <= n_best_val;
        r_removed  <= n_removed;
        r_status   <= n_status;
        // copy of the root entry
        if (o_mem_req.we && o_mem_req.waddr == '0) begin
            r_top <= o_mem_req.wdata;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_result.status        = r_status;
        o_result.removed_value = r_removed;
        o_result.top_value     = (r_cnt != '0) ? r_top : '0;
        o_result.top_valid     = (r_cnt != '0);
        o_result.element_total = r_cnt;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= bmhq_pkg::CAP_CNT)
        else $error("element count above capacity");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state != S_IDLE))
        else $error("request taken but sequencer stayed idle");

    a_up_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CHK) |-> (r_pos != '0 && r_pos <= r_cnt))
        else $error("sift-up position outside the heap");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == bmhq_pkg::ST_FULL) |-> (r_cnt == bmhq_pkg::CAP_CNT))
        else $error("full status with room left");

endmodule

FILE: hdl/binary_max_heap_queue_top.sv
// Top level of the binary max-heap queue: sequencer, heap store, result register.
//
// Binary max-heap of signed 32-bit values, capacity 1024 entries.
// Request channel: i_in_valid with i_req_type (0 insert i_item_value,
// 1 delete maximum); o_in_stall is high while a request is being worked on.
// Result channel: o_out_valid with o_status, o_removed_value, o_top_value,
// o_top_valid and o_element_total; the receiver holds it with i_out_stall.
// Every request gives exactly one result.
// Refused requests go straight to the result. Inserts and deletes run the
// sift loop: each level reads one entry (two for a delete) from the single
// store, compares on the one shared comparator, then writes.
// Throughput: one request at a time; the next is taken the cycle after the
// result moves into the output register.
// Reset (synchronous, active low) empties the heap; store contents need no
// clearing as only written entries are ever read.
// A stalled result waits in the output register while the block already
// takes and works the next request; that one then waits in the sequencer.
module binary_max_heap_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic signed [bmhq_pkg::DATA_W-1:0]  i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bmhq_pkg::STAT_W-1:0]         o_status,
    output logic signed [bmhq_pkg::DATA_W-1:0]  o_removed_value,
    output logic signed [bmhq_pkg::DATA_W-1:0]  o_top_value,
    output logic                                o_top_valid,
    output logic [bmhq_pkg::CNT_W-1:0]          o_element_total
);

    bmhq_pkg::t_mem_req                 mem_req;
    bmhq_pkg::t_result                  seq_result;
    logic signed [bmhq_pkg::DATA_W-1:0] rdata_a, rdata_b;
    logic                               seq_busy, seq_done, take;

    bmhq_pkg::t_result r_out;
    logic              r_out_valid;

    // request accepted only while the sequencer is idle
    assign o_in_stall = seq_busy;

    // result moves on when the output register is empty or being drained
    assign take = seq_done && (!r_out_valid || !i_out_stall);

    bmhq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid),
        .i_req_type   (i_req_type),
        .i_item_value (i_item_value),
        .o_busy       (seq_busy),
        .o_done       (seq_done),
        .i_take       (take),
        .o_result     (seq_result),
        .o_mem_req    (mem_req),
        .i_rdata_a    (rdata_a),
        .i_rdata_b    (rdata_b)
    );

    bmhq_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_removed_value = r_out.removed_value;
    assign o_top_value     = r_out.top_value;
    assign o_top_valid     = r_out.top_valid;
    assign o_element_total = r_out.element_total;

endmodule
